[hw/rtl/lsch_pkg.sv]
// lottery scheduler package: field widths, request kinds and result status codes
// no dependencies; imported by every module of the scheduler
package lsch_pkg;

    localparam int SLOTS_DEF = 8;

    // field widths of a request and a result
    localparam int MODE_W  = 1;
    localparam int SLOT_FW = 3;
    localparam int TIX_W   = 8;
    localparam int REM_W   = 16;
    localparam int RND_W   = 31;
    localparam int STAT_W  = 2;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    // request kinds carried on tuser
    localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
    localparam logic [MODE_W-1:0] MODE_DRAW = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_RAN        = 2'd0;
    localparam logic [STAT_W-1:0] ST_WASTED     = 2'd1;
    localparam logic [STAT_W-1:0] ST_ALL_DONE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_TICKETS = 2'd3;

endpackage

[hw/rtl/lsch_sub.sv]
// shared subtract and compare unit of the lottery scheduler
// depends on lsch_pkg; used for the modulo steps and the slot walk
module lsch_sub
    import lsch_pkg::*;
#(
    parameter int WIDTH = 12
)
(
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             borrow   // a < b
);

    logic [WIDTH:0] full;

    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[WIDTH-1:0];
    assign borrow = full[WIDTH];

endmodule

[hw/rtl/lsch_slot_mem.sv]
// slot table of the lottery scheduler: tickets and remaining time per slot
// depends on lsch_pkg; one write port, one registered read port, valid bits per entry
module lsch_slot_mem
    import lsch_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int SLOT_W = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [SLOT_W-1:0]        wr_addr,
    input  logic [TIX_W+REM_W-1:0]   wr_data,
    input  logic [SLOT_W-1:0]        rd_addr,
    output logic [TIX_W+REM_W-1:0]   rd_data
);

    localparam int DATA_W = TIX_W + REM_W;

    logic [DATA_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    // entries never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_data_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/lottery_scheduler.sv]
// lottery scheduler top level: request decode, sequencer and result register
// depends on lsch_pkg, lsch_sub and lsch_slot_mem
// a load updates the slot table and gives no result; a draw that ends early (all done or no
// tickets) shows its result in the cycle after the request; a full draw runs the restoring
// modulo steps, then walks the slots from slot 0 up to the winner, all on the one shared subtractor
// one request at a time; the next request is taken once the result is taken or a load is written
// reset: asynchronous, active low; clears the ticket total, per-slot valid and alive bits
module lottery_scheduler
    import lsch_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot, ticket_count, burst_length, random_value
    input  logic [MODE_W-1:0]     s_tuser,   // mode
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // chosen_slot, status, finished_now, time_left
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOT_W  = $clog2(SLOTS * ((1 << TIX_W) - 1) + 1);
    localparam int SUB_W  = TOT_W + 1;
    localparam int CNT_W  = $clog2(RND_W);
    localparam int DATA_W = TIX_W + REM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_WALK,
        S_OUT
    } state_t;

    // request fields
    logic [SLOT_FW-1:0] in_slot;
    logic [TIX_W-1:0]   in_tix;
    logic [REM_W-1:0]   in_burst;
    logic [RND_W-1:0]   in_rnd;
    logic               in_fire;
    logic               in_slot_ok;
    logic [SLOT_W+SLOT_FW-1:0] in_slot_wide;
    logic [SLOT_W-1:0]  in_addr;

    assign in_slot  = s_tdata[2:0];
    assign in_tix   = s_tdata[10:3];
    assign in_burst = s_tdata[26:11];
    assign in_rnd   = s_tdata[57:27];
    assign in_fire  = s_tvalid && s_tready;

    // slots at or beyond SLOTS are ignored by a load
    assign in_slot_ok   = (32'(in_slot) < SLOTS);
    assign in_slot_wide = {{SLOT_W{1'b0}}, in_slot};
    assign in_addr      = in_slot_wide[SLOT_W-1:0];

    // sequencer and datapath registers
    state_t             state_reg,  state_next;
    logic [TOT_W-1:0]   total_reg,  total_next;
    logic [SLOTS-1:0]   alive_reg,  alive_next;    // slot has time left
    logic [SLOT_W-1:0]  addr_reg,   addr_next;     // load slot, then walk index
    logic [TIX_W-1:0]   tix_reg,    tix_next;
    logic [REM_W-1:0]   burst_reg,  burst_next;
    logic [RND_W-1:0]   rnd_reg,    rnd_next;      // dividend, shifted out msb first
    logic [TOT_W-1:0]   rem_reg,    rem_next;      // remainder, then walk residue
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [OUT_DATA_W-1:0] out_reg, out_next;

    // memory and shared unit hookup
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [SLOT_W-1:0]  rd_addr;
    logic [DATA_W-1:0]  rd_data;
    logic [TIX_W-1:0]   rd_tix;
    logic [REM_W-1:0]   rd_rem;
    logic [SUB_W-1:0]   sub_a;
    logic [SUB_W-1:0]   sub_b;
    logic [SUB_W-1:0]   sub_diff;
    logic               sub_borrow;

    logic [SUB_W-1:0]   div_shift;
    logic [REM_W-1:0]   rem_dec;
    logic               walk_last;
    logic               walk_hit;
    logic [SLOT_W+SLOT_FW-1:0] pick_wide;
    logic [SLOT_FW-1:0] pick_slot;

    assign rd_tix    = rd_data[REM_W +: TIX_W];
    assign rd_rem    = rd_data[REM_W-1:0];
    assign div_shift = {rem_reg, rnd_reg[RND_W-1]};
    assign rem_dec   = rd_rem - REM_W'(1);
    assign walk_last = (addr_reg == SLOT_W'(SLOTS - 1));
    assign walk_hit  = sub_borrow || walk_last;
    assign pick_wide = {{SLOT_FW{1'b0}}, addr_reg};
    assign pick_slot = pick_wide[SLOT_FW-1:0];

    // operand select for the shared subtractor
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            // restoring step: shifted remainder against the ticket total
            sub_a = div_shift;
            sub_b = {1'b0, total_reg};
        end
        else
        begin
            // walk step: residue of the winning ticket against this slot's tickets
            sub_a = {1'b0, rem_reg};
            sub_b = SUB_W'(rd_tix);
        end
    end

    lsch_sub #(
        .WIDTH (SUB_W)
    ) u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    lsch_slot_mem #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        alive_next = alive_reg;
        addr_next  = addr_reg;
        tix_next   = tix_reg;
        burst_next = burst_reg;
        rnd_next   = rnd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        wr_en      = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = {tix_reg, burst_reg};
        rd_addr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // read the addressed slot so a load sees its old tickets next cycle
                rd_addr = in_addr;
                if (in_fire)
                begin
                    addr_next  = in_addr;
                    tix_next   = in_tix;
                    burst_next = in_burst;
                    rnd_next   = in_rnd;
                    rem_next   = '0;
                    cnt_next   = '0;
                    if (s_tuser == MODE_LOAD)
                    begin
                        if (in_slot_ok)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                    else if (alive_reg == '0)
                    begin
                        out_next   = {2'b00, 16'd0, 1'b0, ST_ALL_DONE, 3'd0};
                        state_next = S_OUT;
                    end
                    else if (total_reg == '0)
                    begin
                        out_next   = {2'b00, 16'd0, 1'b0, ST_NO_TICKETS, 3'd0};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end

            S_LOAD:
            begin
                // reload replaces the slot's old tickets in the total
                total_next = total_reg - TOT_W'(rd_tix) + TOT_W'(tix_reg);
                alive_next[addr_reg] = (burst_reg != '0);
                wr_en      = 1'b1;
                state_next = S_IDLE;
            end

            S_DIV:
            begin
                rem_next = sub_borrow ? div_shift[TOT_W-1:0] : sub_diff[TOT_W-1:0];
                rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RND_W - 1))
                begin
                    // slot 0 is read now for the first walk step
                    addr_next  = '0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                rd_addr = addr_reg + SLOT_W'(1);
                if (walk_hit)
                begin
                    if (rd_rem != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {rd_tix, rem_dec};
                        if (rem_dec == '0)
                        begin
                            alive_next[addr_reg] = 1'b0;
                        end
                        out_next = {2'b00, rem_dec, (rem_dec == '0), ST_RAN, pick_slot};
                    end
                    else
                    begin
                        // winner already finished: draw is wasted
                        out_next = {2'b00, 16'd0, 1'b0, ST_WASTED, pick_slot};
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    rem_next  = sub_diff[TOT_W-1:0];
                    addr_next = addr_reg + SLOT_W'(1);
                end
            end

            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            alive_reg <= '0;
            addr_reg  <= '0;
            tix_reg   <= '0;
            burst_reg <= '0;
            rnd_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            alive_reg <= alive_next;
            addr_reg  <= addr_next;
            tix_reg   <= tix_next;
            burst_reg <= burst_next;
            rnd_reg   <= rnd_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            out_reg   <= out_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg;

    // request and result sides are never open in the same cycle
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request and result sides open together");

    // modulo result lies below the ticket total when the walk starts
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && $past(state_reg) == S_DIV) |-> (rem_reg < total_reg))
        else $error("winning ticket not below ticket total");

    // a finished flag comes only with a ran status and zero time left
    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |-> (m_tdata[4:3] == ST_RAN && m_tdata[21:6] == 16'd0))
        else $error("finished flag without ran status");

    // early results carry no slot and no time
    a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[4:3] == ST_ALL_DONE || m_tdata[4:3] == ST_NO_TICKETS))
            |-> (m_tdata[2:0] == 3'd0 && m_tdata[21:5] == 17'd0))
        else $error("early result carries slot or time");

endmodule
